FILE: rtl/tepq_pkg.sv
// Shared types and constants for the timed event priority queue.
`timescale 1ns / 1ps

package tepq_pkg;

    localparam int QUEUE_DEPTH = 64;
    localparam int TIME_BITS   = 40;
    localparam int KIND_BITS   = 2;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int ERR_W       = 2;
    localparam int OCC_W       = 7;

    // Stream payload widths, padded to whole bytes
    localparam int IN_DATA_W   = ((TIME_BITS + KIND_BITS + 7) / 8) * 8;
    localparam int OUT_USED_W  = 1 + TIME_BITS + KIND_BITS + ERR_W + OCC_W;
    localparam int OUT_DATA_W  = ((OUT_USED_W + 7) / 8) * 8;

    // Operation codes
    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_POP    = 1'b1;

    // Error codes
    localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
    localparam logic [ERR_W-1:0] ERR_EMPTY = 2'd1;
    localparam logic [ERR_W-1:0] ERR_FULL  = 2'd2;

    typedef struct packed {
        logic [TIME_BITS-1:0] time_us;
        logic [KIND_BITS-1:0] kind;
    } t_entry;

    // Command broadcast to every cell of the chain
    typedef struct packed {
        logic   insert;
        logic   pop;
        t_entry new_entry;
    } t_cell_ctrl;

endpackage

FILE: rtl/timed_event_priority_queue.sv
// Top level of the timed event priority queue: cell chain, fill count and result register.
// A request's result is registered and presented in the cycle after it is accepted.
// One insert or pop per cycle unless m_axis stalls; all cells compare and shift at once.
// Reset (synchronous, active low) clears the fill count and the result valid.
// Entry contents are not cleared; slots at or above the fill count are ignored.
`timescale 1ns / 1ps

module timed_event_priority_queue
    import tepq_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [39:0] event_time, [41:40] event_kind, rest zero
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // [0] func
    input  logic                  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [0] popped_valid, [40:1] popped_time, [42:41] popped_kind,
    // [44:43] error, [51:45] occupancy, rest zero
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_out_valid;
    logic             n_out_valid;

    logic                 r_pop_valid;
    logic [TIME_BITS-1:0] r_pop_time;
    logic [KIND_BITS-1:0] r_pop_kind;
    logic [ERR_W-1:0]     r_err;
    logic [ERR_W-1:0]     n_err;

    logic       accept;
    logic       is_pop;
    logic       full;
    logic       empty;
    t_cell_ctrl ctrl;

    t_entry entries [QUEUE_DEPTH];
    logic   places  [QUEUE_DEPTH];

    // Accept while the result register is free or being drained
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign is_pop        = (s_axis_tuser == FUNC_POP);
    assign full          = (r_count == CNT_W'(QUEUE_DEPTH));
    assign empty         = (r_count == '0);

    // Build the command for the chain
    always_comb begin
        ctrl.insert            = accept && !is_pop && !full;
        ctrl.pop               = accept && is_pop && !empty;
        ctrl.new_entry.time_us = s_axis_tdata[TIME_BITS-1:0];
        ctrl.new_entry.kind    = s_axis_tdata[TIME_BITS +: KIND_BITS];
    end

    // Chain of cells, head at index 0
    for (genvar gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
        t_entry left_entry;
        logic   left_place;
        t_entry right_entry;

        if (gi == 0) begin : g_head
            assign left_entry = ctrl.new_entry;
            assign left_place = 1'b0;
        end else begin : g_body
            assign left_entry = entries[gi-1];
            assign left_place = places[gi-1];
        end

        if (gi == QUEUE_DEPTH - 1) begin : g_tail
            assign right_entry = entries[gi];
        end else begin : g_inner
            assign right_entry = entries[gi+1];
        end

        tepq_cell u_cell (
            .i_clk         (i_clk),
            .i_ctrl        (ctrl),
            .i_occupied    (r_count > CNT_W'(gi)),
            .i_left_entry  (left_entry),
            .i_left_place  (left_place),
            .i_right_entry (right_entry),
            .o_entry       (entries[gi]),
            .o_place       (places[gi])
        );
    end

    // Advance the fill count and classify the request
    always_comb begin
        n_count     = r_count;
        n_err       = ERR_OK;
        n_out_valid = r_out_valid && !m_axis_tready;
        if (ctrl.insert) begin
            n_count = r_count + 1'b1;
        end else if (ctrl.pop) begin
            n_count = r_count - 1'b1;
        end
        if (accept) begin
            n_out_valid = 1'b1;
            if (is_pop && empty) begin
                n_err = ERR_EMPTY;
            end else if (!is_pop && full) begin
                n_err = ERR_FULL;
            end
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // Result payload, loaded on each accepted request
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pop_valid <= ctrl.pop;
            r_pop_time  <= ctrl.pop ? entries[0].time_us : '0;
            r_pop_kind  <= ctrl.pop ? entries[0].kind : '0;
            r_err       <= n_err;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {
        {(OUT_DATA_W - OUT_USED_W){1'b0}},
        OCC_W'(r_count),
        r_err,
        r_pop_kind,
        r_pop_time,
        r_pop_valid
    };

endmodule

FILE: rtl/tepq_cell.sv
// One slot of the sorted chain: holds one entry and trades it with its neighbors.
`timescale 1ns / 1ps

module tepq_cell
    import tepq_pkg::*;
(
    input  logic       i_clk,
    input  t_cell_ctrl i_ctrl,
    input  logic       i_occupied,
    input  t_entry     i_left_entry,
    input  logic       i_left_place,
    input  t_entry     i_right_entry,
    output t_entry     o_entry,
    output logic       o_place
);

    t_entry r_entry;
    t_entry n_entry;

    // New event belongs at or before this slot
    assign o_place = !i_occupied || (r_entry.time_us >= i_ctrl.new_entry.time_us);
    assign o_entry = r_entry;

    // Shift right on insert behind the insertion point, shift left on pop
    always_comb begin
        n_entry = r_entry;
        if (i_ctrl.insert) begin
            if (i_left_place) begin
                n_entry = i_left_entry;
            end else if (o_place) begin
                n_entry = i_ctrl.new_entry;
            end
        end else if (i_ctrl.pop) begin
            n_entry = i_right_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule
